@@ sv/checked_int64_text_parser_macros.svh @@
`ifndef CHECKED_INT64_TEXT_PARSER_MACROS_SVH
`define CHECKED_INT64_TEXT_PARSER_MACROS_SVH

// same-cycle implication, held off during reset
`define CIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("checked_int64_text_parser: assertion failed");

// next-cycle implication, held off during reset
`define CIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("checked_int64_text_parser: assertion failed");

`endif

@@ sv/ci64p_pkg.sv @@
package ci64p_pkg;

	typedef enum logic [5:0] {
		PH_LEAD   = 6'b000001,
		PH_SIGNED = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_DIGITS = 6'b001000,
		PH_TRAIL  = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [5:0] BASE_DEFAULT = 6'd10;
	localparam logic [5:0] BASE_DEC     = 6'd10;
	localparam logic [5:0] BASE_HEX     = 6'd16;
	localparam logic [5:0] BASE_OCT     = 6'd8;
	localparam logic [5:0] BASE_MAX     = 6'd36;
	localparam logic [5:0] BASE_AUTO    = 6'd0;
	localparam logic [5:0] BASE_BAD     = 6'd1;
	localparam logic [5:0] NO_DIGIT     = 6'd36;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// 0-9, a-z, A-Z to 0..35; anything else to NO_DIGIT
	function automatic logic [5:0] char_digit(input logic [7:0] c);
		logic [5:0] d;
		if (c >= 8'h30 && c <= 8'h39)
			d = 6'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h7A)
			d = 6'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h5A)
			d = 6'(c - 8'h37);
		else
			d = NO_DIGIT;
		return d;
	endfunction

endpackage

@@ sv/checked_int64_text_parser.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_ready    char_byte[7:0], last_byte
// output    out_valid / out_ready  status[1:0], value[63:0] signed
// config    cfg_we                 cfg_data[5:0] (base_select)
//
// One character per cycle. The character is registered, then a single
// 64x6 multiply-add with a limit compare updates the accumulator.
// out_valid rises when the registered last character writes the result register.
// arst_n clears the parse state; base_select resets to 10.
// Only the last character of a string waits when the result register is full.
`include "checked_int64_text_parser_macros.svh"

module checked_int64_text_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [63:0] value
);
	import ci64p_pkg::*;

	logic [5:0]  base_q;

	logic        v_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic        adv;

	phase_t      phase_q, phase_n;
	logic        neg_q, neg_n;
	logic [63:0] acc_q, acc_n;
	logic [5:0]  eff_q, eff_n;
	logic        saw_q, saw_n;
	logic [1:0]  sticky_q, sticky_n;

	logic        ws;
	logic [5:0]  dig;
	logic [5:0]  b0;
	logic [5:0]  bd;
	logic [69:0] prod;
	logic [69:0] sum;
	logic [69:0] limit;
	logic        ovf;
	logic        take_first;
	logic        take_digit;

	logic [1:0]  st_res;
	logic [63:0] mag_res;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [63:0] mag_q;
	logic        neg_out_q;

	assign adv      = v_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			base_q <= BASE_DEFAULT;
		else if (cfg_we)
			base_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			last_s1 <= last_byte;
		end
	end

	assign ws  = is_ws(char_s1);
	assign dig = char_digit(char_s1);
	// base before the first character is resolved comes straight from the register
	assign b0  = (phase_q == PH_LEAD) ? base_q : eff_q;
	assign bd  = (b0 == BASE_AUTO) ? BASE_DEC : b0;

	// acc*b + d > limit is the same test as acc > (limit - d) / b
	assign prod  = 70'(acc_q) * 70'(bd);
	assign sum   = prod + 70'(dig);
	assign limit = {6'b0, neg_q, {63{~neg_q}}};
	assign ovf   = sum > limit;

	always_comb begin
		phase_n    = phase_q;
		neg_n      = neg_q;
		acc_n      = acc_q;
		eff_n      = eff_q;
		saw_n      = saw_q;
		sticky_n   = sticky_q;
		take_first = 1'b0;
		take_digit = 1'b0;

		unique case (phase_q)
			PH_LEAD: begin
				if (base_q == BASE_BAD || base_q > BASE_MAX) begin
					sticky_n = ST_INVALID;
					phase_n  = PH_DONE;
				end else begin
					eff_n = base_q;
					if (!ws) begin
						if (char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
							neg_n   = (char_s1 == CH_MINUS);
							phase_n = PH_SIGNED;
						end else begin
							take_first = 1'b1;
						end
					end
				end
			end
			PH_SIGNED: begin
				take_first = 1'b1;
			end
			PH_ZERO: begin
				if (char_s1 == CH_LX || char_s1 == CH_UX) begin
					eff_n   = BASE_HEX;
					saw_n   = 1'b0;
					acc_n   = '0;
					phase_n = PH_DIGITS;
				end else begin
					take_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				take_digit = 1'b1;
			end
			PH_TRAIL: begin
				if (!ws) begin
					sticky_n = ST_INVALID;
					phase_n  = PH_DONE;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (take_first) begin
			if ((b0 == BASE_AUTO || b0 == BASE_HEX) && char_s1 == CH_ZERO) begin
				if (b0 == BASE_AUTO)
					eff_n = BASE_OCT;
				saw_n   = 1'b1;
				acc_n   = '0;
				phase_n = PH_ZERO;
			end else begin
				eff_n      = bd;
				take_digit = 1'b1;
			end
		end

		if (take_digit) begin
			if (dig < bd) begin
				saw_n = 1'b1;
				if (ovf) begin
					sticky_n = ST_OVERFLOW;
					phase_n  = PH_DONE;
				end else begin
					acc_n   = sum[63:0];
					phase_n = PH_DIGITS;
				end
			end else if (saw_q && ws) begin
				phase_n = PH_TRAIL;
			end else begin
				sticky_n = ST_INVALID;
				phase_n  = PH_DONE;
			end
		end

		if (sticky_n != ST_OK)
			st_res = sticky_n;
		else if ((phase_n == PH_ZERO || phase_n == PH_DIGITS || phase_n == PH_TRAIL) && saw_n)
			st_res = ST_OK;
		else
			st_res = ST_INVALID;
		mag_res = (st_res == ST_OK) ? acc_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			eff_q    <= '0;
			saw_q    <= 1'b0;
			sticky_q <= ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				phase_q  <= PH_LEAD;
				neg_q    <= 1'b0;
				acc_q    <= '0;
				eff_q    <= '0;
				saw_q    <= 1'b0;
				sticky_q <= ST_OK;
			end else begin
				phase_q  <= phase_n;
				neg_q    <= neg_n;
				acc_q    <= acc_n;
				eff_q    <= eff_n;
				saw_q    <= saw_n;
				sticky_q <= sticky_n;
			end
		end
	end

	// result register; the sign is applied on the way out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			status_q  <= st_res;
			mag_q     <= mag_res;
			neg_out_q <= neg_n;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = $signed(neg_out_q ? (64'd0 - mag_q) : mag_q);

	`CIP_ASSERT_IMPL(a_done_has_error, clk, arst_n, phase_q == PH_DONE, sticky_q != ST_OK)
	`CIP_ASSERT_IMPL(a_base_resolved, clk, arst_n,
		phase_q == PH_ZERO || phase_q == PH_DIGITS || phase_q == PH_TRAIL,
		eff_q >= 6'd2 && eff_q <= BASE_MAX)
	`CIP_ASSERT_NEXT(a_clear_after_last, clk, arst_n, adv && last_s1,
		phase_q == PH_LEAD && acc_q == 64'd0 && !saw_q && sticky_q == ST_OK)
	`CIP_ASSERT_IMPL(a_result_in_range, clk, arst_n, out_valid_q,
		(status_q != ST_OK && mag_q == 64'd0) || (status_q == ST_OK && (neg_out_q || !mag_q[63])))

endmodule
